/* hw/rtl/pls_pkg.sv */
// shared types, constants and handshake structs for the positional list store
// no dependencies
`timescale 1ns / 1ps

package pls_pkg;

  // default sizing of the store
  localparam int unsigned MAX_ENTRIES_C = 64;
  localparam int unsigned DATA_WIDTH_C  = 32;

  // fixed field widths on the ports
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 7;

  // each read-tree level picks one of this many nodes
  localparam int unsigned TREE_RADIX = 8;
  localparam int unsigned DIGIT_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_POS   = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] entry_data;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic              removed_valid;
    logic [WORD_W-1:0] removed_data;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // capture request, restart read walk
    logic commit;  // apply request, load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;  // read tree output matches current request
  } dp_stat_t;

  // number of registered 8-way levels needed to reach any of n entries
  function automatic int unsigned tree_levels(input int unsigned n);
    int unsigned lv;
    lv = ($clog2(n) + DIGIT_W - 1) / DIGIT_W;
    if (lv == 0) begin
      lv = 1;
    end
    return lv;
  endfunction

endpackage

/* hw/rtl/positional_list_store_unit.sv */
// top level of the positional list store: ordered list with front, back and
// positional insert/remove; instantiates pls_ctrl and pls_dpath, uses pls_pkg
`timescale 1ns / 1ps

//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | to block  | in_valid_i / in_ready_o   | in_data_i  (op, position, entry_data)
//  out     | from block| out_valid_o / out_ready_i | out_data_o (status, removed_valid,
//          |           |                           |   removed_data, entry_count)
//
//  one beat in gives one beat out; the next beat is accepted only after the current one
//  has walked the registered 8-way read tree, LEVELS = ceil(log2(MAX_ENTRIES) / 3) deep,
//  that fetches the removed word
//  reset clears the count and the handshake state; slot contents stay unknown
//  a stalled result holds in the output register; the next beat is taken and
//  walked meanwhile, and waits to commit until the output register frees up

module positional_list_store_unit
  import pls_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_C,
  parameter int unsigned DATA_WIDTH  = DATA_WIDTH_C
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: accepts beats, waits for the read walk, commits when the
  // output register is free
  pls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: shifting cell row, count, read tree and result register
  pls_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (out_data_o)
  );

endmodule

/* hw/rtl/pls_ctrl.sv */
// control state machine of the positional list store
// uses pls_pkg; drives pls_dpath through dp_cmd_t, reads dp_stat_t
`timescale 1ns / 1ps

module pls_ctrl
  import pls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        commit_ok;

  assign commit_ok = stat_i.walk_done && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (commit_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.start  = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_WALK: begin
        cmd_o.commit = commit_ok;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a committed request shows its result and frees the input side
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q && in_ready_o)
    else $error("commit did not present a result");

  // no new beat is taken while one is in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat accepted during a walk");

endmodule

/* hw/rtl/pls_dpath.sv */
// datapath of the positional list store: shifting cell row, read tree, result register
// uses pls_pkg; controlled by pls_ctrl
`timescale 1ns / 1ps

module pls_dpath
  import pls_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_C,
  parameter int unsigned DATA_WIDTH  = DATA_WIDTH_C
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output rsp_t     rsp_o
);

  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW  = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned LVLS  = tree_levels(MAX_ENTRIES);
  localparam int unsigned SELW  = LVLS * DIGIT_W;
  localparam int unsigned NODES = 1 << (DIGIT_W * (LVLS - 1));
  localparam int unsigned WCW   = $clog2(LVLS + 1);

  req_t                  req_q;
  logic [CW-1:0]         count_q, count_d;
  logic [WCW-1:0]        walk_q;
  logic [DATA_WIDTH-1:0] slots_q [MAX_ENTRIES];
  logic [DATA_WIDTH-1:0] stage_q [LVLS][NODES];
  rsp_t                  rsp_q;

  logic [CMPW-1:0]       cnt_ext, pos_ext, at;
  logic [SELW-1:0]       sel;
  logic                  full, empty, do_ins, do_rm;
  status_e               st;
  logic [DATA_WIDTH-1:0] wr_word;

  // request register and walk counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (cmd_i.start) begin
      walk_q <= '0;
    end else if (!stat_o.walk_done) begin
      walk_q <= walk_q + WCW'(1);
    end
  end

  assign stat_o.walk_done = (walk_q == WCW'(LVLS));

  // decode the request against the current count
  always_comb begin
    cnt_ext = CMPW'(count_q);
    pos_ext = CMPW'(req_q.position);
    full    = (count_q == CW'(MAX_ENTRIES));
    empty   = (count_q == '0);
    st      = ST_OK;
    do_ins  = 1'b0;
    do_rm   = 1'b0;
    at      = '0;
    unique case (op_e'(req_q.op))
      OP_INS_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_INS_BACK: begin
        at = cnt_ext;
        if (full) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_INS_POS: begin
        at = pos_ext;
        if (full) begin
          st = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          st = ST_BADPOS;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          do_rm = 1'b1;
        end
      end
      OP_REM_BACK: begin
        at = cnt_ext - CMPW'(1);
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          do_rm = 1'b1;
        end
      end
      OP_REM_POS: begin
        at = pos_ext;
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          st = ST_BADPOS;
        end else begin
          do_rm = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign sel     = SELW'(at);
  assign wr_word = DATA_WIDTH'(req_q.entry_data);

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_rm) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  // cell row: every cell at or above the target shifts at once, away from it on insert, toward it on remove
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic below, here;
    assign below = (CMPW'(i) < at);
    assign here  = (CMPW'(i) == at);
    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        if (do_ins && !below) begin
          if (here) begin
            slots_q[i] <= wr_word;
          end else begin
            if (i > 0) begin
              slots_q[i] <= slots_q[(i > 0) ? i - 1 : 0];
            end
          end
        end else if (do_rm && !below) begin
          if (i < MAX_ENTRIES - 1) begin
            slots_q[i] <= slots_q[(i < MAX_ENTRIES - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  // registered 8-way read tree, lowest digit first
  for (genvar n = 0; n < NODES; n++) begin : g_leaf
    logic [DATA_WIDTH-1:0] grp [TREE_RADIX];
    for (genvar m = 0; m < TREE_RADIX; m++) begin : g_in
      if (n * TREE_RADIX + m < MAX_ENTRIES) begin : g_used
        assign grp[m] = slots_q[n * TREE_RADIX + m];
      end else begin : g_pad
        assign grp[m] = '0;
      end
    end
    always_ff @(posedge clk_i) begin
      stage_q[0][n] <= grp[sel[DIGIT_W-1:0]];
    end
  end

  for (genvar k = 1; k < LVLS; k++) begin : g_lvl
    for (genvar n = 0; n < (NODES >> (DIGIT_W * k)); n++) begin : g_node
      logic [DATA_WIDTH-1:0] grp [TREE_RADIX];
      for (genvar m = 0; m < TREE_RADIX; m++) begin : g_in
        assign grp[m] = stage_q[k-1][n * TREE_RADIX + m];
      end
      always_ff @(posedge clk_i) begin
        stage_q[k][n] <= grp[sel[k*DIGIT_W +: DIGIT_W]];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q.status        <= st;
      rsp_q.removed_valid <= do_rm;
      rsp_q.removed_data  <= do_rm ? WORD_W'(stage_q[LVLS-1][0]) : '0;
      rsp_q.entry_count   <= CNT_W'(count_d);
    end
  end

  assign rsp_o = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count beyond store size");

  a_count_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> rsp_q.entry_count == CNT_W'(count_q))
    else $error("reported count differs from held count");

  a_commit_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> stat_o.walk_done && !cmd_i.start)
    else $error("commit before read tree settled");

endmodule

/* tb/tb.sv */
// self-checking bench for positional_list_store_unit: directed edge beats, then
// random fill, drain and churn traffic with stalls on both sides
// depends on pls_pkg and the rtl of the list store
`timescale 1ns / 1ps

module tb
  import pls_pkg::*;
;

  // op codes the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam int unsigned RANDOM_BEATS = 1030;
  localparam int unsigned QUIET_BEATS  = 150;   // tail of the run with no idling
  localparam int unsigned HOLD_CYCLES  = 90;    // long receiver hold-off
  localparam int unsigned DRAIN_LIMIT  = 10000;
  localparam int unsigned TAIL_CYCLES  = 20;

  typedef enum int {
    TRAFFIC_CHURN,
    TRAFFIC_FILL,
    TRAFFIC_DRAIN
  } traffic_e;

  // list contents mirror and queue of pending responses
  class list_scoreboard;
    logic [WORD_W-1:0] words[$];
    rsp_t              rsp_q[$];
    int unsigned       errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned held();
      return words.size();
    endfunction

    function int unsigned pending();
      return rsp_q.size();
    endfunction

    // apply one accepted request to the mirror and queue its response
    function void note_request(req_t r);
      rsp_t        exp;
      int unsigned cnt;
      int unsigned pos;
      cnt = words.size();
      pos = 32'(r.position);
      exp = '0;
      exp.status = ST_OK;
      if (r.op == OP_INS_FRONT || r.op == OP_INS_BACK || r.op == OP_INS_POS) begin
        if (cnt >= MAX_ENTRIES_C) begin
          exp.status = ST_FULL;
        end else if (r.op == OP_INS_FRONT) begin
          words.push_front(r.entry_data);
        end else if (r.op == OP_INS_BACK) begin
          words.push_back(r.entry_data);
        end else if (pos > cnt) begin
          exp.status = ST_BADPOS;
        end else begin
          words.insert(pos, r.entry_data);
        end
      end else if (r.op == OP_REM_FRONT || r.op == OP_REM_BACK || r.op == OP_REM_POS) begin
        if (cnt == 0) begin
          exp.status = ST_EMPTY;
        end else if (r.op == OP_REM_FRONT) begin
          exp.removed_data  = words.pop_front();
          exp.removed_valid = 1'b1;
        end else if (r.op == OP_REM_BACK) begin
          exp.removed_data  = words.pop_back();
          exp.removed_valid = 1'b1;
        end else if (pos >= cnt) begin
          exp.status = ST_BADPOS;
        end else begin
          exp.removed_data  = words[pos];
          exp.removed_valid = 1'b1;
          words.delete(pos);
        end
      end
      exp.entry_count = CNT_W'(words.size());
      rsp_q.push_back(exp);
    endfunction

    function void field_mismatch(string name, longint unsigned exp, longint unsigned got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, got);
      errors++;
    endfunction

    // compare one returned beat with the oldest pending response
    function void check_result(rsp_t got);
      rsp_t exp;
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected response beat, expected none, got %0h", $time, got);
        errors++;
        return;
      end
      exp = rsp_q.pop_front();
      if (got.status !== exp.status)
        field_mismatch("status", 64'(exp.status), 64'(got.status));
      if (got.removed_valid !== exp.removed_valid)
        field_mismatch("removed_valid", 64'(exp.removed_valid), 64'(got.removed_valid));
      if (got.removed_data !== exp.removed_data)
        field_mismatch("removed_data", 64'(exp.removed_data), 64'(got.removed_data));
      if (got.entry_count !== exp.entry_count)
        field_mismatch("entry_count", 64'(exp.entry_count), 64'(got.entry_count));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  // stimulus knobs, all written with nonblocking assignments
  logic tx_gaps_on = 1'b0;
  logic rx_gaps_on = 1'b0;
  logic rx_hold    = 1'b0;
  logic hold_go    = 1'b0;

  list_scoreboard sb = new();

  positional_list_store_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case the handshake hangs
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // response side: short random stall bursts, plus one long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
        // start a stall burst, this one included; stall_left counts the rest of it
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // long hold-off, counted here so the sender keeps offering beats meanwhile
  initial begin
    wait (hold_go === 1'b1);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // response monitor; values read here are the ones present at the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_data_o);
    end
  end

  function automatic req_t mk(logic [OP_W-1:0] op, int unsigned pos, logic [WORD_W-1:0] d);
    req_t r;
    r.op         = op;
    r.position   = pos[POS_W-1:0];
    r.entry_data = d;
    return r;
  endfunction

  // offer one beat, hold it until taken, then maybe leave a gap
  task automatic send(input req_t r);
    in_data_i  <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // sender stops until every response has come back
  task automatic wait_drained();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // random request shaped by the traffic mix and the current list size
  function automatic req_t pick_request(traffic_e mix);
    int unsigned      roll;
    int unsigned      cnt;
    int unsigned      pos;
    int unsigned      ins_pct;
    logic [OP_W-1:0]  op;
    logic [WORD_W-1:0] d;
    cnt  = sb.held();
    roll = $urandom_range(0, 99);
    case (mix)
      TRAFFIC_FILL:  ins_pct = 93;
      TRAFFIC_DRAIN: ins_pct = 7;
      default:       ins_pct = 50;
    endcase
    if (roll < 3) begin
      op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    end else if (roll < 3 + ins_pct - 3 * ins_pct / 100) begin
      case ($urandom_range(0, 2))
        0:       op = OP_INS_FRONT;
        1:       op = OP_INS_BACK;
        default: op = OP_INS_POS;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       op = OP_REM_FRONT;
        1:       op = OP_REM_BACK;
        default: op = OP_REM_POS;
      endcase
    end
    // mostly legal positions, some anywhere in the field
    if ($urandom_range(0, 99) < 15) begin
      pos = $urandom_range(0, 127);
    end else if (op == OP_INS_POS) begin
      pos = $urandom_range(0, cnt);
    end else begin
      pos = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
    end
    case ($urandom_range(0, 19))
      0:       d = '0;
      1:       d = '1;
      default: d = $urandom;
    endcase
    return mk(op, pos, d);
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned waited;
    traffic_e    mix;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, bad positions, both ends, ignored op codes
    send(mk(OP_REM_FRONT, 0, 32'h0));
    send(mk(OP_REM_BACK, 0, 32'h0));
    send(mk(OP_REM_POS, 0, 32'h0));          // empty wins over the position check
    send(mk(OP_REM_POS, 127, 32'h0));
    send(mk(OP_UNUSED_6, 0, 32'hFFFF_FFFF));
    send(mk(OP_INS_POS, 1, 32'h1234_5678));  // past the end of an empty list
    send(mk(OP_INS_POS, 0, 32'hFFFF_FFFF));
    send(mk(OP_INS_FRONT, 0, 32'h0000_0000));
    send(mk(OP_INS_BACK, 0, 32'hA5A5_A5A5));
    send(mk(OP_INS_POS, 3, 32'h5A5A_5A5A));  // position equal to count
    send(mk(OP_INS_POS, 5, 32'h0000_0001));
    send(mk(OP_INS_POS, 127, 32'h8000_0000));
    send(mk(OP_INS_POS, 64, 32'h7FFF_FFFF));
    send(mk(OP_REM_POS, 4, 32'h0));          // position equal to count
    send(mk(OP_REM_POS, 1, 32'hFFFF_FFFF));
    send(mk(OP_UNUSED_7, 127, 32'h0));
    send(mk(OP_REM_BACK, 0, 32'h0));
    send(mk(OP_INS_POS, 1, 32'hDEAD_BEEF));
    send(mk(OP_REM_FRONT, 0, 32'h0));
    send(mk(OP_REM_POS, 0, 32'h0));
    send(mk(OP_REM_POS, 0, 32'h0));
    send(mk(OP_REM_FRONT, 0, 32'h0));
    wait_drained();

    // random: phases of fill, churn and drain so full and empty are both hit
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      case (phase % 4)
        0:       mix = TRAFFIC_FILL;
        2:       mix = TRAFFIC_DRAIN;
        default: mix = TRAFFIC_CHURN;
      endcase
      phase_len = (mix == TRAFFIC_CHURN) ? 60 : 85;
      if (sent + QUIET_BEATS >= RANDOM_BEATS) begin
        tx_gaps_on <= 1'b0;
        rx_gaps_on <= 1'b0;
      end else if (phase == 5) begin
        // one long receiver hold-off with the sender offering back to back
        tx_gaps_on <= 1'b0;
        rx_gaps_on <= ($urandom_range(0, 3) != 0);
        hold_go    <= 1'b1;
      end else begin
        tx_gaps_on <= ($urandom_range(0, 3) != 0);
        rx_gaps_on <= ($urandom_range(0, 3) != 0);
      end
      for (int unsigned k = 0; k < phase_len && sent < RANDOM_BEATS; k++) begin
        send(pick_request(mix));
        sent++;
      end
      if (phase % 3 == 2) begin
        wait_drained();
      end
      phase++;
    end

    // let the last responses come back
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
    end
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d responses never arrived, expected 0 pending, got %0d",
               $time, sb.pending(), sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
